>>> src/acip_pkg.sv
package acip_pkg;

   localparam int unsigned COORD_W = 8;
   localparam int unsigned SIZE_W = 9;
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 9;

   localparam int unsigned CW = 14;
   localparam int unsigned PW = 28;
   localparam int unsigned GEO_W = 12;
   localparam int unsigned NW = 17;
   localparam int unsigned RECIP_W = 18;
   localparam int unsigned RECIP_SHIFT = 22;
   localparam logic [RECIP_W-1:0] RECIP = 18'd167773;

   localparam int unsigned NUM_PCT = 15;
   localparam int unsigned P_CTOP = 0;
   localparam int unsigned P_CBOT = 1;
   localparam int unsigned P_CTL = 2;
   localparam int unsigned P_CTR = 3;
   localparam int unsigned P_CBL = 4;
   localparam int unsigned P_CBR = 5;
   localparam int unsigned P_HCX = 6;
   localparam int unsigned P_HCY = 7;
   localparam int unsigned P_HOUT = 8;
   localparam int unsigned P_HIN = 9;
   localparam int unsigned P_STOP = 10;
   localparam int unsigned P_SBOT = 11;
   localparam int unsigned P_SL = 12;
   localparam int unsigned P_SR = 13;
   localparam int unsigned P_CLIP = 14;

   localparam logic [6:0] PCT_TABLE [NUM_PCT] = '{
      7'd22, 7'd64, 7'd18, 7'd58, 7'd26, 7'd50, 7'd60, 7'd36,
      7'd17, 7'd9, 7'd71, 7'd81, 7'd10, 7'd72, 7'd2
   };

   localparam logic [CSR_INDEX_W-1:0] REG_ICON_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_LEVEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_LEVEL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_LEVEL = 2'd3;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [PW-1:0] wide_type;

   typedef struct packed {
      coord_type ctop;
      coord_type cbot;
      coord_type ctl;
      coord_type ctr;
      coord_type hcx;
      coord_type hcy;
      coord_type hout;
      coord_type hin;
      coord_type stop;
      coord_type sbot;
      coord_type srad;
      coord_type capl;
      coord_type capr;
      coord_type capy;
      coord_type clip;
      coord_type span;
      coord_type slope_l;
      coord_type slope_r;
      wide_type [3:0] span_step;
      wide_type [3:0] left_step;
      wide_type [3:0] right_step;
      wide_type hout_sq;
      wide_type hin_sq;
      wide_type srad_sq;
   } geo_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] alpha;
   } pix_type;

endpackage

>>> src/acip_ifs.sv
interface acip_req_if;
   logic valid;
   logic ready;
   logic [7:0] pixel_col;
   logic [7:0] pixel_row;
   modport source (output valid, pixel_col, pixel_row, input ready);
   modport sink (input valid, pixel_col, pixel_row, output ready);
endinterface

interface acip_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic [7:0] out_alpha;
   modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
   modport sink (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

interface acip_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [8:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

>>> src/antialiased_cup_icon_pixel.sv
// Cup-on-saucer icon pixel source. Each req transaction carries one pixel
// coordinate and yields one rsp transaction with a premultiplied BGRA pixel
// (4x4 subsample coverage of a tapered cup, ring handle and rounded saucer,
// tinted by the color registers). One pixel is accepted per clock while the
// skid stage has room and the bounds are settled; each result passes through
// six pipeline stages, the first loaded at the accepting edge, then the output
// register of a two-entry skid stage so req keeps flowing while a result waits.
// Shape bounds come from a four-stage geometry pipeline fed by the icon_size
// register: after reset and after every csr write, req_if.ready stays low while
// the bounds settle. Write registers only while no pixel is in flight.
module antialiased_cup_icon_pixel
   import acip_pkg::*;
#(
   parameter int MAX_EDGE = 256
) (
   input  logic       clock,
   input  logic       reset,
   acip_req_if.sink   req_if,
   acip_rsp_if.source rsp_if,
   acip_csr_if.sink   csr_if
);

   localparam logic [2:0] GEO_LAT = 3'd4;

   logic [SIZE_W-1:0]  icon_in, icon_ff;
   logic [LEVEL_W-1:0] red_in, red_ff, green_in, green_ff, blue_in, blue_ff;
   logic [2:0]         settle_in, settle_ff;
   logic               csr_write, accept, adv;
   geo_type            geo;
   logic               cov_valid, shade_valid;
   logic [15:0]        lit;
   pix_type            shade_pix, out_pix;

   assign csr_if.ready = 1'b1;
   assign csr_write = csr_if.valid && csr_if.ready;
   assign req_if.ready = adv && (settle_ff == 3'd0);
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      icon_in = icon_ff;
      red_in = red_ff;
      green_in = green_ff;
      blue_in = blue_ff;
      settle_in = settle_ff;
      if (settle_ff != 3'd0) begin
         settle_in = settle_ff - 3'd1;
      end
      if (csr_write) begin
         settle_in = GEO_LAT;
         unique case (csr_if.index)
            REG_ICON_SIZE: begin
               icon_in = csr_if.wdata[SIZE_W-1:0];
            end
            REG_RED_LEVEL: begin
               red_in = csr_if.wdata[LEVEL_W-1:0];
            end
            REG_GREEN_LEVEL: begin
               green_in = csr_if.wdata[LEVEL_W-1:0];
            end
            REG_BLUE_LEVEL: begin
               blue_in = csr_if.wdata[LEVEL_W-1:0];
            end
            default: begin
               icon_in = icon_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icon_ff <= 9'd32;
         red_ff <= 8'd255;
         green_ff <= 8'd255;
         blue_ff <= 8'd255;
         settle_ff <= GEO_LAT;
      end else begin
         icon_ff <= icon_in;
         red_ff <= red_in;
         green_ff <= green_in;
         blue_ff <= blue_in;
         settle_ff <= settle_in;
      end
   end

   acip_geometry #(
      .MAX_EDGE (MAX_EDGE)
   ) u_geometry (
      .clock     (clock),
      .icon_size (icon_ff),
      .geo       (geo)
   );

   acip_coverage u_coverage (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (accept),
      .pixel_col (req_if.pixel_col),
      .pixel_row (req_if.pixel_row),
      .geo       (geo),
      .out_valid (cov_valid),
      .lit       (lit)
   );

   acip_shade u_shade (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (cov_valid),
      .lit         (lit),
      .red_level   (red_ff),
      .green_level (green_ff),
      .blue_level  (blue_ff),
      .out_valid   (shade_valid),
      .pix         (shade_pix)
   );

   acip_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shade_valid),
      .in_pix    (shade_pix),
      .out_ready (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .out_pix   (out_pix),
      .adv       (adv)
   );

   assign rsp_if.out_blue = out_pix.blue;
   assign rsp_if.out_green = out_pix.green;
   assign rsp_if.out_red = out_pix.red;
   assign rsp_if.out_alpha = out_pix.alpha;

endmodule

>>> src/acip_geometry.sv
module acip_geometry
   import acip_pkg::*;
#(
   parameter int MAX_EDGE = 256
) (
   input  logic              clock,
   input  logic [SIZE_W-1:0] icon_size,
   output geo_type           geo
);

   localparam logic [10:0] EDGE_LIMIT = 11'(MAX_EDGE);

   logic [SIZE_W-1:0]           size_c;
   logic [NW-1:0]               prod_in [NUM_PCT];
   logic [NW-1:0]               prod_ff [NUM_PCT];
   logic [NW+RECIP_W-1:0]       recip_prod [NUM_PCT];
   logic [GEO_W-1:0]            pct_in [NUM_PCT];
   logic [GEO_W-1:0]            pct_ff [NUM_PCT];
   coord_type                   bound [NUM_PCT];
   geo_type                     geo3_in;
   geo_type                     geo3_ff;
   geo_type                     geo4_in;
   geo_type                     geo4_ff;

   always_comb begin
      if (icon_size < 9'd8) begin
         size_c = 9'd8;
      end else if ({2'b00, icon_size} > EDGE_LIMIT) begin
         size_c = SIZE_W'(MAX_EDGE);
      end else begin
         size_c = icon_size;
      end
      for (int i = 0; i < NUM_PCT; i++) begin
         prod_in[i] = NW'(size_c) * NW'({PCT_TABLE[i], 1'b0});
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_PCT; i++) begin
         recip_prod[i] = (NW+RECIP_W)'(prod_ff[i]) * (NW+RECIP_W)'(RECIP);
         pct_in[i] = recip_prod[i][RECIP_SHIFT +: GEO_W];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_PCT; i++) begin
         bound[i] = $signed({{(CW-GEO_W){1'b0}}, pct_ff[i]});
      end
      geo3_in = '0;
      geo3_in.ctop = bound[P_CTOP];
      geo3_in.cbot = bound[P_CBOT];
      geo3_in.ctl = bound[P_CTL];
      geo3_in.ctr = bound[P_CTR];
      geo3_in.hcx = bound[P_HCX];
      geo3_in.hcy = bound[P_HCY];
      geo3_in.hout = bound[P_HOUT];
      geo3_in.hin = bound[P_HIN];
      geo3_in.stop = bound[P_STOP];
      geo3_in.sbot = bound[P_SBOT];
      geo3_in.srad = (bound[P_SBOT] - bound[P_STOP]) >>> 1;
      geo3_in.capl = bound[P_SL] + geo3_in.srad;
      geo3_in.capr = bound[P_SR] - geo3_in.srad;
      geo3_in.capy = (bound[P_STOP] + bound[P_SBOT]) >>> 1;
      geo3_in.clip = bound[P_CTR] - bound[P_CLIP];
      geo3_in.span = bound[P_CBOT] - bound[P_CTOP];
      geo3_in.slope_l = bound[P_CBL] - bound[P_CTL];
      geo3_in.slope_r = bound[P_CTR] - bound[P_CBR];
   end

   always_comb begin
      geo4_in = geo3_ff;
      for (int j = 0; j < 4; j++) begin
         geo4_in.span_step[j] = wide_type'(geo3_ff.span) * wide_type'(2 * j + 2);
         geo4_in.left_step[j] = wide_type'(geo3_ff.slope_l) * wide_type'(2 * j + 1);
         geo4_in.right_step[j] = wide_type'(geo3_ff.slope_r) * wide_type'(2 * j + 1);
      end
      geo4_in.hout_sq = wide_type'(geo3_ff.hout) * wide_type'(geo3_ff.hout);
      geo4_in.hin_sq = wide_type'(geo3_ff.hin) * wide_type'(geo3_ff.hin);
      geo4_in.srad_sq = wide_type'(geo3_ff.srad) * wide_type'(geo3_ff.srad);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pct_ff <= pct_in;
      geo3_ff <= geo3_in;
      geo4_ff <= geo4_in;
   end

   assign geo = geo4_ff;

endmodule

>>> src/acip_coverage.sv
module acip_coverage
   import acip_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] pixel_col,
   input  logic [COORD_W-1:0] pixel_row,
   input  geo_type            geo,
   output logic               out_valid,
   output logic [15:0]        lit
);

   // stage 1: subsample offsets
   logic      v1_ff;
   coord_type xb_in, xb_ff, xr_in, xr_ff, yo_in, yo_ff;
   coord_type hdx_in [4], hdx_ff [4], sdx_in [4], sdx_ff [4];
   coord_type hdy_in [4], hdy_ff [4], sdy_in [4], sdy_ff [4];
   logic [3:0] clp_in, clp1_ff, sin_in, sin1_ff, cin_in, cin1_ff, srow_in, srow1_ff;
   coord_type xj, yi, c8, r8;

   // stage 2: products
   logic      v2_ff;
   wide_type  bl_in, bl_ff, br_in, br_ff, nl_in, nl_ff, nr_in, nr_ff;
   wide_type  hdx2_in [4], hdx2_ff [4], sdx2_in [4], sdx2_ff [4];
   wide_type  hdy2_in [4], hdy2_ff [4], sdy2_in [4], sdy2_ff [4];
   logic [3:0] clp2_ff, sin2_ff, cin2_ff, srow2_ff;

   // stage 3: edge terms and distances
   logic      v3_ff;
   wide_type  tl_in [4], tl_ff [4], tr_in [4], tr_ff [4];
   wide_type  nlr_in [4], nlr_ff [4], nrr_in [4], nrr_ff [4];
   wide_type  hd2_in [16], hd2_ff [16], sd2_in [16], sd2_ff [16];
   logic [3:0] clp3_ff, sin3_ff, cin3_ff, srow3_ff;

   // stage 4: subsample hits
   logic      v4_ff;
   logic [15:0] lit_in, lit_ff;

   always_comb begin
      c8 = $signed({3'b000, pixel_col, 3'b000});
      r8 = $signed({3'b000, pixel_row, 3'b000});
      xb_in = c8 - geo.ctl;
      xr_in = geo.ctr - c8;
      yo_in = r8 - geo.ctop;
      for (int j = 0; j < 4; j++) begin
         xj = $signed({3'b000, pixel_col, 2'(j), 1'b1});
         hdx_in[j] = xj - geo.hcx;
         clp_in[j] = xj >= geo.clip;
         sin_in[j] = (xj >= geo.capl) && (xj <= geo.capr);
         sdx_in[j] = (xj < geo.capl) ? (xj - geo.capl) : (xj - geo.capr);
      end
      for (int i = 0; i < 4; i++) begin
         yi = $signed({3'b000, pixel_row, 2'(i), 1'b1});
         hdy_in[i] = yi - geo.hcy;
         sdy_in[i] = yi - geo.capy;
         cin_in[i] = (yi >= geo.ctop) && (yi <= geo.cbot);
         srow_in[i] = (yi >= geo.stop) && (yi <= geo.sbot);
      end
   end

   always_comb begin
      bl_in = wide_type'(xb_ff) * wide_type'(geo.span);
      br_in = wide_type'(xr_ff) * wide_type'(geo.span);
      nl_in = wide_type'(yo_ff) * wide_type'(geo.slope_l);
      nr_in = wide_type'(yo_ff) * wide_type'(geo.slope_r);
      for (int k = 0; k < 4; k++) begin
         hdx2_in[k] = wide_type'(hdx_ff[k]) * wide_type'(hdx_ff[k]);
         sdx2_in[k] = wide_type'(sdx_ff[k]) * wide_type'(sdx_ff[k]);
         hdy2_in[k] = wide_type'(hdy_ff[k]) * wide_type'(hdy_ff[k]);
         sdy2_in[k] = wide_type'(sdy_ff[k]) * wide_type'(sdy_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         tl_in[k] = bl_ff + geo.span_step[k];
         nlr_in[k] = nl_ff + geo.left_step[k];
         nrr_in[k] = nr_ff + geo.right_step[k];
      end
      tr_in[0] = br_ff;
      for (int k = 1; k < 4; k++) begin
         tr_in[k] = br_ff - geo.span_step[k-1];
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            hd2_in[i*4+j] = hdx2_ff[j] + hdy2_ff[i];
            sd2_in[i*4+j] = sdx2_ff[j] + sdy2_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            lit_in[i*4+j] =
               (cin3_ff[i] && (tl_ff[j] > nlr_ff[i]) && (tr_ff[j] > nrr_ff[i])) ||
               (clp3_ff[j] && (hd2_ff[i*4+j] <= geo.hout_sq) &&
                (hd2_ff[i*4+j] >= geo.hin_sq)) ||
               (srow3_ff[i] && (sin3_ff[j] || (sd2_ff[i*4+j] <= geo.srad_sq)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xb_ff <= xb_in;
         xr_ff <= xr_in;
         yo_ff <= yo_in;
         hdx_ff <= hdx_in;
         sdx_ff <= sdx_in;
         hdy_ff <= hdy_in;
         sdy_ff <= sdy_in;
         clp1_ff <= clp_in;
         sin1_ff <= sin_in;
         cin1_ff <= cin_in;
         srow1_ff <= srow_in;

         bl_ff <= bl_in;
         br_ff <= br_in;
         nl_ff <= nl_in;
         nr_ff <= nr_in;
         hdx2_ff <= hdx2_in;
         sdx2_ff <= sdx2_in;
         hdy2_ff <= hdy2_in;
         sdy2_ff <= sdy2_in;
         clp2_ff <= clp1_ff;
         sin2_ff <= sin1_ff;
         cin2_ff <= cin1_ff;
         srow2_ff <= srow1_ff;

         tl_ff <= tl_in;
         tr_ff <= tr_in;
         nlr_ff <= nlr_in;
         nrr_ff <= nrr_in;
         hd2_ff <= hd2_in;
         sd2_ff <= sd2_in;
         clp3_ff <= clp2_ff;
         sin3_ff <= sin2_ff;
         cin3_ff <= cin2_ff;
         srow3_ff <= srow2_ff;

         lit_ff <= lit_in;
      end
   end

   assign out_valid = v4_ff;
   assign lit = lit_ff;

endmodule

>>> src/acip_shade.sv
module acip_shade
   import acip_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [15:0]        lit,
   input  logic [LEVEL_W-1:0] red_level,
   input  logic [LEVEL_W-1:0] green_level,
   input  logic [LEVEL_W-1:0] blue_level,
   output logic               out_valid,
   output pix_type            pix
);

   function automatic logic [LEVEL_W-1:0] div255(input logic [2*LEVEL_W-1:0] v);
      logic [2*LEVEL_W:0] t;
      t = (2*LEVEL_W+1)'(v) + (2*LEVEL_W+1)'(v[2*LEVEL_W-1:LEVEL_W]) + 17'd1;
      return t[2*LEVEL_W-1:LEVEL_W];
   endfunction

   logic [4:0]           cov;
   logic [12:0]          cov_scaled;
   logic                 v5_ff, v6_ff;
   logic [LEVEL_W-1:0]   alpha_in, alpha5_ff, alpha6_ff;
   logic [2*LEVEL_W-1:0] pb_in, pb_ff, pg_in, pg_ff, pr_in, pr_ff;

   always_comb begin
      cov = 5'($countones(lit));
      cov_scaled = 13'(cov) * 13'd255;
      alpha_in = cov_scaled[11:4];
      pb_in = (2*LEVEL_W)'(blue_level) * (2*LEVEL_W)'(alpha5_ff);
      pg_in = (2*LEVEL_W)'(green_level) * (2*LEVEL_W)'(alpha5_ff);
      pr_in = (2*LEVEL_W)'(red_level) * (2*LEVEL_W)'(alpha5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= in_valid;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         alpha5_ff <= alpha_in;
         alpha6_ff <= alpha5_ff;
         pb_ff <= pb_in;
         pg_ff <= pg_in;
         pr_ff <= pr_in;
      end
   end

   assign out_valid = v6_ff;
   assign pix.blue = div255(pb_ff);
   assign pix.green = div255(pg_ff);
   assign pix.red = div255(pr_ff);
   assign pix.alpha = alpha6_ff;

endmodule

>>> src/acip_out_skid.sv
module acip_out_skid
   import acip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  pix_type in_pix,
   input  logic    out_ready,
   output logic    out_valid,
   output pix_type out_pix,
   output logic    adv
);

   logic    main_v_in, main_v_ff, skid_v_in, skid_v_ff;
   pix_type main_in, main_ff, skid_in, skid_ff;
   logic    push, pop;

   assign adv = !skid_v_ff;
   assign push = in_valid && adv;
   assign pop = main_v_ff && out_ready;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      if (skid_v_ff) begin
         if (pop) begin
            main_in = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (!main_v_ff || pop) begin
         main_v_in = push;
         main_in = in_pix;
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in = in_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_v_ff;
   assign out_pix = main_ff;

endmodule

>>> bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import acip_pkg::*;

   localparam int MAX_EDGE = 256;
   localparam int IDLE_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 200;

   localparam int CUP_TOP_PCT = 22;
   localparam int CUP_BOTTOM_PCT = 64;
   localparam int CUP_TOP_LEFT_PCT = 18;
   localparam int CUP_TOP_RIGHT_PCT = 58;
   localparam int CUP_BOT_LEFT_PCT = 26;
   localparam int CUP_BOT_RIGHT_PCT = 50;
   localparam int HANDLE_X_PCT = 60;
   localparam int HANDLE_Y_PCT = 36;
   localparam int HANDLE_OUTER_PCT = 17;
   localparam int HANDLE_INNER_PCT = 9;
   localparam int SAUCER_TOP_PCT = 71;
   localparam int SAUCER_BOTTOM_PCT = 81;
   localparam int SAUCER_LEFT_PCT = 10;
   localparam int SAUCER_RIGHT_PCT = 72;

   localparam pix_type CLEAR_PIX = '0;
   localparam pix_type WHITE_PIX = '1;
   localparam pix_type TINT_PIX = {8'hFF, 8'h5A, 8'hA5, 8'hFF};

   typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_op_type;
   typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_type;

   // pixel rows: a = col, b = row; config rows: a = size, b = red, c = green, d = blue
   typedef struct {
      row_op_type op;
      logic [8:0] a;
      logic [8:0] b;
      logic [8:0] c;
      logic [8:0] d;
      bit known;
      pix_type want;
   } plan_row_type;

   plan_row_type opening_plan [26] = '{
      '{ROW_PIXEL,  9'd0,   9'd0,   9'd0,   9'd0,   1'b1, CLEAR_PIX},
      '{ROW_PIXEL,  9'd12,  9'd12,  9'd0,   9'd0,   1'b1, WHITE_PIX},
      '{ROW_PIXEL,  9'd255, 9'd255, 9'd0,   9'd0,   1'b1, CLEAR_PIX},
      '{ROW_PIXEL,  9'd31,  9'd31,  9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd255, 9'd0,   9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd0,   9'd255, 9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd23,  9'd11,  9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd16,  9'd24,  9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd4,   9'd24,  9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_CONFIG, 9'd32,  9'h0A5, 9'h05A, 9'h1FF, 1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd12,  9'd12,  9'd0,   9'd0,   1'b1, TINT_PIX},
      '{ROW_PIXEL,  9'd6,   9'd8,   9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_CONFIG, 9'd0,   9'd0,   9'd255, 9'd128, 1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd3,   9'd3,   9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd7,   9'd7,   9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd255, 9'd255, 9'd0,   9'd0,   1'b1, CLEAR_PIX},
      '{ROW_CONFIG, 9'd511, 9'd255, 9'd0,   9'd511, 1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd96,  9'd96,  9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd200, 9'd90,  9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd255, 9'd255, 9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_CONFIG, 9'd256, 9'd0,   9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd128, 9'd120, 9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd0,   9'd0,   9'd0,   9'd0,   1'b1, CLEAR_PIX},
      '{ROW_CONFIG, 9'd8,   9'd255, 9'd255, 9'd255, 1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd2,   9'd3,   9'd0,   9'd0,   1'b0, CLEAR_PIX},
      '{ROW_PIXEL,  9'd7,   9'd0,   9'd0,   9'd0,   1'b0, CLEAR_PIX}
   };

   logic clock = 1'b0;
   logic reset;

   acip_req_if req_if ();
   acip_rsp_if rsp_if ();
   acip_csr_if csr_if ();

   antialiased_cup_icon_pixel #(.MAX_EDGE(MAX_EDGE)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   logic [SIZE_W-1:0] cfg_icon_size = 9'd32;
   logic [LEVEL_W-1:0] cfg_red = 8'd255;
   logic [LEVEL_W-1:0] cfg_green = 8'd255;
   logic [LEVEL_W-1:0] cfg_blue = 8'd255;

   pix_type pending_pixels [$];
   int mismatch_count = 0;
   int burst_left = 0;
   int gap_max = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic pix_type shade_pixel(logic [7:0] col, logic [7:0] row);
      longint size, s8, cup_top, cup_bot, cup_tl, cup_tr, cup_bl, cup_br;
      longint ring_x, ring_y, ring_out, ring_in, clip;
      longint sau_top, sau_bot, sau_left, sau_right, sau_rad, cap_l, cap_r, cap_y;
      longint x, y, lx, rx, dx, dy, d2;
      int cov;
      int alpha;
      bit lit;
      pix_type pix;
      cov = 0;
      size = longint'(cfg_icon_size);
      if (size < 8) size = 8;
      if (size > MAX_EDGE) size = MAX_EDGE;
      s8 = size * 8;
      cup_top = (s8 * CUP_TOP_PCT) / 100;
      cup_bot = (s8 * CUP_BOTTOM_PCT) / 100;
      cup_tl = (s8 * CUP_TOP_LEFT_PCT) / 100;
      cup_tr = (s8 * CUP_TOP_RIGHT_PCT) / 100;
      cup_bl = (s8 * CUP_BOT_LEFT_PCT) / 100;
      cup_br = (s8 * CUP_BOT_RIGHT_PCT) / 100;
      ring_x = (s8 * HANDLE_X_PCT) / 100;
      ring_y = (s8 * HANDLE_Y_PCT) / 100;
      ring_out = (s8 * HANDLE_OUTER_PCT) / 100;
      ring_in = (s8 * HANDLE_INNER_PCT) / 100;
      sau_top = (s8 * SAUCER_TOP_PCT) / 100;
      sau_bot = (s8 * SAUCER_BOTTOM_PCT) / 100;
      sau_left = (s8 * SAUCER_LEFT_PCT) / 100;
      sau_right = (s8 * SAUCER_RIGHT_PCT) / 100;
      sau_rad = (sau_bot - sau_top) / 2;
      cap_l = sau_left + sau_rad;
      cap_r = sau_right - sau_rad;
      cap_y = (sau_top + sau_bot) / 2;
      clip = cup_tr - s8 / 50;
      for (int sy = 0; sy < 4; sy++) begin
         for (int sx = 0; sx < 4; sx++) begin
            x = longint'(col) * 8 + sx * 2 + 1;
            y = longint'(row) * 8 + sy * 2 + 1;
            lit = 1'b0;
            if (y >= cup_top && y <= cup_bot) begin
               if (cup_bot == cup_top) begin
                  lx = cup_tl;
                  rx = cup_tr;
               end else begin
                  lx = cup_tl + ((cup_bl - cup_tl) * (y - cup_top)) / (cup_bot - cup_top);
                  rx = cup_tr + ((cup_br - cup_tr) * (y - cup_top)) / (cup_bot - cup_top);
               end
               lit = (x >= lx && x <= rx);
            end
            if (!lit && x >= clip) begin
               dx = x - ring_x;
               dy = y - ring_y;
               d2 = dx * dx + dy * dy;
               if (d2 <= ring_out * ring_out && d2 >= ring_in * ring_in) lit = 1'b1;
            end
            if (!lit && y >= sau_top && y <= sau_bot) begin
               if (x >= cap_l && x <= cap_r) begin
                  lit = 1'b1;
               end else begin
                  dx = x - ((x < cap_l) ? cap_l : cap_r);
                  dy = y - cap_y;
                  if (dx * dx + dy * dy <= sau_rad * sau_rad) lit = 1'b1;
               end
            end
            if (lit) cov++;
         end
      end
      alpha = (cov * 255) / 16;
      pix.alpha = 8'(alpha);
      pix.blue = 8'((int'(cfg_blue) * alpha) / 255);
      pix.green = 8'((int'(cfg_green) * alpha) / 255);
      pix.red = 8'((int'(cfg_red) * alpha) / 255);
      return pix;
   endfunction

   function automatic logic [8:0] pick_level();
      case ($urandom_range(0, 4))
         0: return 9'd0;
         1: return 9'd255;
         2: return 9'h100;
         default: return 9'($urandom_range(0, 511));
      endcase
   endfunction

   task automatic note_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic wait_for_results();
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic send_pixel(logic [7:0] col, logic [7:0] row, bit known, pix_type want);
      if (gap_max > 0 && burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(1, 48);
      end
      req_if.valid <= 1'b1;
      req_if.pixel_col <= col;
      req_if.pixel_row <= row;
      do @(posedge clock); while (!req_if.ready);
      pending_pixels.push_back(known ? want : shade_pixel(col, row));
      if (burst_left > 0) burst_left--;
   endtask

   task automatic write_regs(logic [8:0] size, logic [8:0] red, logic [8:0] green,
                             logic [8:0] blue);
      logic [8:0] vals [4];
      logic [CSR_INDEX_W-1:0] regs [4];
      vals = '{size, red, green, blue};
      regs = '{REG_ICON_SIZE, REG_RED_LEVEL, REG_GREEN_LEVEL, REG_BLUE_LEVEL};
      req_if.valid <= 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= regs[i];
         csr_if.wdata <= vals[i];
         do @(posedge clock); while (!csr_if.ready);
         case (regs[i])
            REG_ICON_SIZE: cfg_icon_size = vals[i];
            REG_RED_LEVEL: cfg_red = vals[i][7:0];
            REG_GREEN_LEVEL: cfg_green = vals[i][7:0];
            default: cfg_blue = vals[i][7:0];
         endcase
      end
      csr_if.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      pix_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_pixels.size() == 0) begin
            note_mismatch($sformatf("result %02h%02h%02h%02h with no pixel pending",
                          rsp_if.out_blue, rsp_if.out_green, rsp_if.out_red,
                          rsp_if.out_alpha));
         end else begin
            want = pending_pixels.pop_front();
            check_field("blue", rsp_if.out_blue, want.blue);
            check_field("green", rsp_if.out_green, want.green);
            check_field("red", rsp_if.out_red, want.red);
            check_field("alpha", rsp_if.out_alpha, want.alpha);
         end
      end
   end

   initial begin
      rx_mode_type rx_mode;
      int rx_window;
      int stall_left;
      rx_mode = RX_STEADY;
      rx_window = 0;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_window == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_window = $urandom_range(100, 600);
         end else begin
            rx_window--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY: rsp_if.ready <= 1'b1;
               RX_LIGHT: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY: rsp_if.ready <= ($urandom_range(0, 2) == 0);
               default: begin
                  if ($urandom_range(0, 15) == 0) begin
                     stall_left = $urandom_range(4, 25);
                     rsp_if.ready <= 1'b0;
                  end else begin
                     rsp_if.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("antialiased_cup_icon_pixel test failed");
      $finish;
   end

   initial begin
      int eff;
      logic [7:0] col;
      logic [7:0] row;
      logic [8:0] size;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.pixel_col = 8'd0;
      req_if.pixel_row = 8'd0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_ICON_SIZE;
      csr_if.wdata = 9'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i]) begin
         if (opening_plan[i].op == ROW_CONFIG)
            write_regs(opening_plan[i].a, opening_plan[i].b, opening_plan[i].c,
                       opening_plan[i].d);
         else
            send_pixel(opening_plan[i].a[7:0], opening_plan[i].b[7:0],
                       opening_plan[i].known, opening_plan[i].want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0: size = 9'($urandom_range(0, 7));
            1: size = 9'd8;
            2: size = 9'd256;
            3: size = 9'($urandom_range(257, 511));
            4: size = 9'd511;
            5: size = 9'($urandom_range(9, 255));
            default: size = 9'($urandom_range(8, 40));
         endcase
         write_regs(size, pick_level(), pick_level(), pick_level());
         gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 20);
         burst_left = 0;
         eff = int'(cfg_icon_size);
         if (eff < 8) eff = 8;
         if (eff > MAX_EDGE) eff = MAX_EDGE;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == RANDOM_PHASES / 2 && n == PHASE_ITEMS / 2) begin
               req_if.valid <= 1'b0;
               wait_for_results();
            end
            if ($urandom_range(0, 99) < 85) begin
               col = 8'($urandom_range(0, eff - 1));
               row = 8'($urandom_range(0, eff - 1));
            end else begin
               col = 8'($urandom_range(0, 255));
               row = 8'($urandom_range(0, 255));
            end
            send_pixel(col, row, 1'b0, CLEAR_PIX);
         end
      end

      req_if.valid <= 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("antialiased_cup_icon_pixel test passed");
      else
         $display("antialiased_cup_icon_pixel test failed");
      $finish;
   end

endmodule
